// ===== hdl/atbr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atbr_pkg
// Shared types and constants for the adaptive threshold beat rate block.
// ----------------------------------------------------------------------------
package atbr_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int TIME_BITS   = 32;
   localparam int GAP_BITS    = 8;
   localparam int WINDOW_BITS = 16;
   localparam int CNT_BITS    = 16;
   localparam int RATE_BITS   = 16;
   localparam int CSR_BITS    = 16;
   localparam int DIV_BITS    = 32;
   localparam int STEP_BITS   = $clog2(DIV_BITS);

   localparam logic [GAP_BITS-1:0]    GAP_RESET     = GAP_BITS'(10);
   localparam logic [WINDOW_BITS-1:0] WINDOW_RESET  = WINDOW_BITS'(1000);
   localparam logic [CNT_BITS-1:0]    CNT_MAX       = '1;
   localparam logic [CNT_BITS-1:0]    MS_PER_MINUTE = CNT_BITS'(60000);

   typedef enum logic {
      CSR_MIN_BEAT_GAP   = 1'b0,
      CSR_RATE_WINDOW_MS = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] ir_level;
      logic [TIME_BITS-1:0]   time_ms;
   } req_type;

   typedef struct packed {
      logic                 rate_valid;
      logic [RATE_BITS-1:0] pulse_rate;
      logic                 beat_seen;
   } rsp_type;

endpackage

// ===== hdl/adaptive_threshold_beat_rate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_threshold_beat_rate
// Adaptive-threshold peak beat detector with a windowed heart-rate estimate.
// ----------------------------------------------------------------------------
// Sequence: an accepted sample is evaluated and its result is then registered at
//   the output; when a rate is computed, a multiply and 32 divider steps come first.
// Samples are taken one at a time, after the previous result is loaded for output.
//   A new item is taken while the previous result still waits at the output.
// Reset: synchronous, clears detector state, sequencer and output valid;
//   registers return to min_beat_gap = 10 and rate_window_ms = 1000.
module adaptive_threshold_beat_rate (
   input  logic                          clock,
   input  logic                          reset,
   // sample channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  atbr_pkg::req_type             req_data,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output atbr_pkg::rsp_type             rsp_data,
   // register writes
   input  logic                          csr_wr_en,
   input  atbr_pkg::csr_index_type       csr_index,
   input  logic [atbr_pkg::CSR_BITS-1:0] csr_wdata
);
   import atbr_pkg::*;

   // ---------------------------------------------------------------- registers
   logic [GAP_BITS-1:0]    gap_ff;
   logic [WINDOW_BITS-1:0] window_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff    <= GAP_RESET;
         window_ff <= WINDOW_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MIN_BEAT_GAP:   gap_ff    <= csr_wdata[GAP_BITS-1:0];
            CSR_RATE_WINDOW_MS: window_ff <= csr_wdata[WINDOW_BITS-1:0];
            default:            ;
         endcase
      end
   end

   // ---------------------------------------------------------------- state
   state_type              state_ff, state_in;
   req_type                item_ff, item_in;          // captured sample
   logic [SAMPLE_BITS-1:0] thresh_ff, thresh_in;      // running threshold
   logic [SAMPLE_BITS-1:0] prev_ff, prev_in;          // previous sample
   logic [CNT_BITS-1:0]    beats_ff, beats_in;        // beats in window
   logic [TIME_BITS-1:0]   last_ff, last_in;          // time of last rate update
   logic [CNT_BITS-1:0]    since_ff, since_in;        // samples since last beat
   logic                   disarm_ff, disarm_in;
   logic [TIME_BITS-1:0]   elapsed_ff, elapsed_in;
   logic                   beat_ff, beat_in;          // result flags under work
   logic                   rvalid_ff, rvalid_in;
   logic                   out_valid_ff, out_valid_in;
   rsp_type                out_ff, out_in;

   // divider hookup
   logic                   div_start;
   logic [DIV_BITS-1:0]    div_dividend;
   logic                   div_done;
   logic [DIV_BITS-1:0]    div_quotient;

   // evaluation terms
   logic [SAMPLE_BITS-1:0] s;
   logic [SAMPLE_BITS-1:0] th_base;
   logic [SAMPLE_BITS+3:0] th_sum;
   logic [SAMPLE_BITS-1:0] th_new;
   logic [CNT_BITS-1:0]    since_inc;
   logic [CNT_BITS-1:0]    beats_inc;
   logic [TIME_BITS-1:0]   elapsed;
   logic                   rising;
   logic                   gap_ok;
   logic                   out_free;

   assign div_dividend = DIV_BITS'(beats_ff) * DIV_BITS'(MS_PER_MINUTE);

   atbr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (elapsed_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      s         = item_ff.ir_level;
      // a zero threshold is loaded from the sample before the filter step
      th_base   = (thresh_ff == '0) ? s : thresh_ff;
      th_sum    = ({4'b0, th_base} << 3) - {4'b0, th_base} + {4'b0, s};
      th_new    = th_sum[SAMPLE_BITS+2:3];
      since_inc = (since_ff == CNT_MAX) ? CNT_MAX : since_ff + CNT_BITS'(1);
      beats_inc = (beats_ff == CNT_MAX) ? CNT_MAX : beats_ff + CNT_BITS'(1);
      elapsed   = item_ff.time_ms - last_ff;      // wraps modulo 2^32
      rising    = (s > prev_ff) && (s > th_new) && !disarm_ff;
      gap_ok    = since_inc > {{(CNT_BITS-GAP_BITS){1'b0}}, gap_ff};
      out_free  = !out_valid_ff || rsp_ready;

      state_in     = state_ff;
      item_in      = item_ff;
      thresh_in    = thresh_ff;
      prev_in      = prev_ff;
      beats_in     = beats_ff;
      last_in      = last_ff;
      since_in     = since_ff;
      disarm_in    = disarm_ff;
      elapsed_in   = elapsed_ff;
      beat_in      = beat_ff;
      rvalid_in    = rvalid_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      div_start    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            // take the next sample even if a result still waits downstream
            req_ready = 1'b1;
            if (req_valid) begin
               item_in  = req_data;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            thresh_in  = th_new;
            prev_in    = s;
            since_in   = since_inc;
            beat_in    = 1'b0;
            rvalid_in  = 1'b0;
            elapsed_in = elapsed;
            state_in   = ST_DONE;
            if (rising) begin
               if (gap_ok) begin
                  beats_in  = beats_inc;
                  since_in  = '0;
                  disarm_in = 1'b1;
                  beat_in   = 1'b1;
                  if (elapsed > {{(TIME_BITS-WINDOW_BITS){1'b0}}, window_ff}) begin
                     rvalid_in = 1'b1;
                     last_in   = item_ff.time_ms;
                     state_in  = ST_MUL;
                  end
               end
            end else if (s < th_new) begin
               disarm_in = 1'b0;
            end
         end
         ST_MUL: begin
            // product goes straight into the divider's dividend register
            div_start = 1'b1;
            beats_in  = '0;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_in.rate_valid = rvalid_ff;
               out_in.beat_seen  = beat_ff;
               if (!rvalid_ff) begin
                  out_in.pulse_rate = '0;
               end else if (div_quotient[DIV_BITS-1:RATE_BITS] != '0) begin
                  out_in.pulse_rate = '1;      // saturate
               end else begin
                  out_in.pulse_rate = div_quotient[RATE_BITS-1:0];
               end
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thresh_ff    <= '0;
         prev_ff      <= '0;
         beats_ff     <= '0;
         last_ff      <= '0;
         since_ff     <= '0;
         disarm_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thresh_ff    <= thresh_in;
         prev_ff      <= prev_in;
         beats_ff     <= beats_in;
         last_ff      <= last_in;
         since_ff     <= since_in;
         disarm_ff    <= disarm_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      elapsed_ff <= elapsed_in;
      beat_ff    <= beat_in;
      rvalid_ff  <= rvalid_in;
      out_ff     <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // ---------------------------------------------------------------- checks
   a_zero_rate_when_invalid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.rate_valid || rsp_data.pulse_rate == '0))
      else $error("pulse_rate nonzero without rate_valid");

   a_rate_needs_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_data.rate_valid || rsp_data.beat_seen))
      else $error("rate emitted on a sample that was not a beat");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide phase");

   a_accept_to_eval: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_EVAL))
      else $error("accepted transfer not evaluated next cycle");

endmodule

// ===== hdl/atbr_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atbr_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module atbr_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [atbr_pkg::DIV_BITS-1:0] dividend,
   input  logic [atbr_pkg::DIV_BITS-1:0] divisor,
   output logic                          done,
   output logic [atbr_pkg::DIV_BITS-1:0] quotient
);
   import atbr_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_BITS-1:0]  cnt_ff, cnt_in;
   logic [DIV_BITS-1:0]   rem_ff, rem_in;
   logic [DIV_BITS-1:0]   quo_ff, quo_in;
   logic [DIV_BITS-1:0]   dsr_ff, dsr_in;
   logic [DIV_BITS:0]     rem_sh;
   logic [DIV_BITS:0]     rem_sub;
   logic                  fits;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[DIV_BITS-1]};
      rem_sub = rem_sh - {1'b0, dsr_ff};
      fits    = rem_sh >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         rem_in = fits ? rem_sub[DIV_BITS-1:0] : rem_sh[DIV_BITS-1:0];
         quo_in = {quo_ff[DIV_BITS-2:0], fits};
         cnt_in = cnt_ff + STEP_BITS'(1);
         if (cnt_ff == STEP_BITS'(DIV_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
